// ----- rtl/header_length_sum_deframer_defines.svh -----
// header_length_sum_deframer_defines.svh: assertion macros for the deframer checker
// no dependencies; included by the checker file
`ifndef HEADER_LENGTH_SUM_DEFRAMER_DEFINES_SVH
`define HEADER_LENGTH_SUM_DEFRAMER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define HLSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define HLSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hlsd_pkg.sv -----
// hlsd_pkg.sv: types and constants shared by the deframer modules
// no dependencies
package hlsd_pkg;

  // fixed field widths
  localparam int BYTE_W      = 8;
  localparam int FRAME_LEN_W = 5;

  // header register reset values
  localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'h77;

  // configuration register indexes
  localparam logic CFG_HDR_FIRST  = 1'b0;
  localparam logic CFG_HDR_SECOND = 1'b1;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SUM = 1'b1;

  // header kind codes
  localparam logic KIND_FIRST  = 1'b0;
  localparam logic KIND_SECOND = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic take_hdr;   // latch header byte, start sum
    logic take_len;   // latch length byte, add to sum
    logic take_pay;   // store payload byte, add to sum
    logic clr_idx;    // restart byte index for read-out
    logic rd_en;      // read payload memory at index
    logic load_pay;   // load payload result into output register
    logic load_err;   // load error result into output register
  } hlsd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hdr_match;  // incoming byte matches a header
    logic len_ok;     // incoming byte is a legal length
    logic idx_last;   // index points at final payload byte
    logic sum_ok;     // incoming byte equals running sum
    logic out_free;   // output register can take a result
  } hlsd_sts_t;

endpackage

// ----- rtl/hlsd_ram.sv -----
// hlsd_ram.sv: generic single-write, single-read RAM with registered read
// no dependencies
module hlsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 17,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/hlsd_ctrl.sv -----
// hlsd_ctrl.sv: frame controller state machine for the deframer
// depends on hlsd_pkg
module hlsd_ctrl
  import hlsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hlsd_sts_t sts,
  output hlsd_cmd_t cmd
);

  localparam logic [2:0] S_HUNT = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_PAY  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;
  localparam logic [2:0] S_ERR  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  // input is taken only while collecting frame bytes
  assign in_stall = !((state_r == S_HUNT) || (state_r == S_LEN) ||
                      (state_r == S_PAY)  || (state_r == S_CHK));
  assign acc      = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (acc && sts.hdr_match) begin
          cmd.take_hdr = 1'b1;
          state_nxt    = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          if (sts.len_ok) begin
            cmd.take_len = 1'b1;
            state_nxt    = S_PAY;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_PAY: begin
        if (acc) begin
          cmd.take_pay = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (acc) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = sts.sum_ok ? S_RD : S_ERR;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_pay = 1'b1;
          state_nxt    = sts.idx_last ? S_HUNT : S_RD;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_HUNT;
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/hlsd_dpath.sv -----
// hlsd_dpath.sv: deframer datapath: header registers, sum, index, payload store, output
// depends on hlsd_pkg and hlsd_ram
module hlsd_dpath
  import hlsd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [BYTE_W-1:0]      in_rx_byte,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  input  hlsd_cmd_t              cmd,
  output hlsd_sts_t              sts,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BYTE_W-1:0]      out_payload_byte,
  output logic                   out_header_kind,
  output logic [FRAME_LEN_W-1:0] out_frame_length,
  output logic                   out_status,
  output logic                   out_last
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0]      hdr_first_r, hdr_second_r;
  logic                   kind_r;
  logic [LW-1:0]          len_r;
  logic [LW-1:0]          idx_r;
  logic [BYTE_W-1:0]      sum_r;
  logic [BYTE_W-1:0]      rd_data;
  logic                   out_valid_r;
  logic [BYTE_W-1:0]      out_payload_r;
  logic                   out_kind_r;
  logic [FRAME_LEN_W-1:0] out_len_r;
  logic                   out_status_r;
  logic                   out_last_r;

  // status toward the controller
  assign sts.hdr_match = (in_rx_byte == hdr_first_r) || (in_rx_byte == hdr_second_r);
  assign sts.len_ok    = (in_rx_byte != '0) && (in_rx_byte <= BYTE_W'(MAX_PAYLOAD));
  assign sts.idx_last  = (idx_r == (len_r - LW'(1)));
  assign sts.sum_ok    = (in_rx_byte == sum_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // header value registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HDR_FIRST_RST;
      hdr_second_r <= HDR_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HDR_FIRST) begin
        hdr_first_r <= cfg_data;
      end else begin
        hdr_second_r <= cfg_data;
      end
    end
  end

  // running sum and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.take_hdr) begin
        sum_r <= in_rx_byte;
        idx_r <= '0;
      end else if (cmd.take_len || cmd.take_pay) begin
        sum_r <= sum_r + in_rx_byte;
      end
      if (cmd.take_pay || cmd.load_pay) begin
        idx_r <= idx_r + LW'(1);
      end else if (cmd.clr_idx) begin
        idx_r <= '0;
      end
    end
  end

  // frame header fields, latched once per frame
  always_ff @(posedge clk) begin
    if (cmd.take_hdr) begin
      kind_r <= (in_rx_byte == hdr_first_r) ? KIND_FIRST : KIND_SECOND;
    end
    if (cmd.take_len) begin
      len_r <= in_rx_byte[LW-1:0];
    end
  end

  // payload store
  hlsd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.take_pay),
    .wr_addr (idx_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_pay || cmd.load_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_pay || cmd.load_err) begin
      out_kind_r <= kind_r;
      out_len_r  <= FRAME_LEN_W'(len_r);
    end
    if (cmd.load_pay) begin
      out_payload_r <= rd_data;
      out_status_r  <= STATUS_OK;
      out_last_r    <= sts.idx_last;
    end else if (cmd.load_err) begin
      out_payload_r <= '0;
      out_status_r  <= STATUS_BAD_SUM;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_payload_r;
  assign out_header_kind  = out_kind_r;
  assign out_frame_length = out_len_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

// ----- rtl/header_length_sum_deframer.sv -----
// header_length_sum_deframer.sv: top level of the serial frame deframer
// depends on hlsd_pkg, hlsd_ctrl, hlsd_dpath (and hlsd_ram through it)
//
// Takes received bytes one per item and finds frames of the form header, length L
// (1..MAX_PAYLOAD), L payload bytes, checksum (8-bit wrapping sum of header, length
// and payload). A good frame yields its L payload bytes as a run of result items with
// last on the final one; a bad checksum yields one error item (status 1, payload 0).
// While collecting a frame the block takes one byte per cycle. Payload bytes sit in a
// small RAM with a registered read port, so after the checksum byte each payload byte
// is first read from the RAM and then loaded into the output register, each load
// waiting while the output is stalled; input is stalled for that whole read-out.
// Header values are written through the cfg port; the user must write them only while
// the block idles, and the block itself does not enforce this.
module header_length_sum_deframer
  import hlsd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BYTE_W-1:0]      out_payload_byte,
  output logic                   out_header_kind,
  output logic [FRAME_LEN_W-1:0] out_frame_length,
  output logic                   out_status,
  output logic                   out_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  hlsd_cmd_t cmd;
  hlsd_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // frame controller
  hlsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  hlsd_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_header_kind  (out_header_kind),
    .out_frame_length (out_frame_length),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

// ----- rtl/hlsd_checker.sv -----
// hlsd_checker.sv: port-level assertions for the deframer, bound to the top level
// depends on hlsd_pkg and header_length_sum_deframer_defines.svh
`include "header_length_sum_deframer_defines.svh"

module hlsd_checker
  import hlsd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [BYTE_W-1:0]      out_payload_byte,
  input logic                   out_status,
  input logic                   out_last
);

  // a held result keeps its payload
  `HLSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload_byte), "result changed while stalled")

  // an error item is a single zero item with last set
  `HLSD_ASSERT_NOW(a_err_shape, out_valid && (out_status == STATUS_BAD_SUM), (out_payload_byte == '0) && out_last, "malformed error item")

  // no byte is taken in the middle of a payload run
  `HLSD_ASSERT_NOW(a_run_busy, out_valid && !out_last, in_stall, "input open during a payload run")

endmodule

bind header_length_sum_deframer hlsd_checker u_hlsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_payload_byte (out_payload_byte),
  .out_status       (out_status),
  .out_last         (out_last)
);
